FILE: rtl/core/assert_macros.svh
// Assertion macros for the detector RTL.
// Depends on nothing; expects clk_i and rst_ni in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, also during reset.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/lcdd_pkg.sv
// Types and constants of the launch and chute deploy detector.
// No dependencies.
package lcdd_pkg;

  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned AxisW = 16;
  localparam int unsigned PressW = 16;
  localparam int unsigned MagW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LAUNCH_MAG_SQ = 4'd0,
    CFG_STILL_MAG_SQ  = 4'd1,
    CFG_PRESS_RISE    = 4'd2,
    CFG_DEPLOY_DELAY  = 4'd3
  } lcdd_cfg_idx_e;

  localparam logic [MagW-1:0]     LaunchMagSqReset = 32'd42949672;
  localparam logic [MagW-1:0]     StillMagSqReset  = 32'd24159192;
  localparam logic [PressW-1:0]   PressRiseReset   = 16'd4;
  localparam logic [CfgDataW-1:0] DeployDelayReset = 32'd13000000;

  typedef struct packed {
    logic [MagW-1:0]     launch_mag_sq_limit;
    logic [MagW-1:0]     still_mag_sq_limit;
    logic [PressW-1:0]   pressure_rise_limit;
    logic [CfgDataW-1:0] deploy_delay_us;
  } lcdd_cfg_t;

  typedef struct packed {
    logic launched;
    logic deploy_armed;
    logic falling;
  } lcdd_flags_t;

  typedef struct packed {
    logic deploy;
    logic launch_seen;
    logic fall_seen;
  } lcdd_result_t;

endpackage

FILE: rtl/core/lcdd_ifs.sv
// Handshake channels of the detector: samples in, results out, register writes.
// Depends on lcdd_pkg.
interface lcdd_sample_if #(
  parameter int unsigned TIME_BITS = 48
);
  logic                        valid;
  logic                        ready;
  logic signed [15:0]          accel_x;
  logic signed [15:0]          accel_y;
  logic signed [15:0]          accel_z;
  logic [15:0]                 pressure_tenths;
  logic [TIME_BITS-1:0]        time_us;

  modport source (output valid, accel_x, accel_y, accel_z, pressure_tenths, time_us,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, pressure_tenths, time_us,
                  output ready);
endinterface

interface lcdd_result_if;
  logic valid;
  logic ready;
  logic deploy;
  logic launch_seen;
  logic fall_seen;

  modport source (output valid, deploy, launch_seen, fall_seen, input ready);
  modport sink   (input valid, deploy, launch_seen, fall_seen, output ready);
endinterface

interface lcdd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lcdd_pkg::CfgIdxW-1:0] index;
  logic [lcdd_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/lcdd_step.sv
// Per-sample evaluation: squared magnitude, launch, delay, fall and deploy.
// Depends on lcdd_pkg. Purely combinational.
module lcdd_step #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic signed [15:0]       ax_i,
  input  logic signed [15:0]       ay_i,
  input  logic signed [15:0]       az_i,
  input  logic [15:0]              press_i,
  input  logic [TIME_BITS-1:0]     now_i,
  input  lcdd_pkg::lcdd_cfg_t      cfg_i,
  input  lcdd_pkg::lcdd_flags_t    flags_i,
  input  logic [TIME_BITS-1:0]     stamp_i,
  input  logic [15:0]              last_press_i,
  output lcdd_pkg::lcdd_flags_t    flags_o,
  output logic [TIME_BITS-1:0]     stamp_o,
  output logic [15:0]              last_press_o,
  output lcdd_pkg::lcdd_result_t   result_o
);
  import lcdd_pkg::*;

  logic signed [31:0]    sq_x, sq_y, sq_z;
  logic [MagW-1:0]       mag;
  logic                  launch_now;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  has_base;
  logic signed [16:0]    diff;
  logic                  rise;

  // Each square is below 2^31, the sum below 2^32.
  assign sq_x = ax_i * ax_i;
  assign sq_y = ay_i * ay_i;
  assign sq_z = az_i * az_i;
  assign mag  = unsigned'(sq_x) + unsigned'(sq_y) + unsigned'(sq_z);

  assign launch_now = !flags_i.launched && (mag > cfg_i.launch_mag_sq_limit);
  assign stamp_o    = launch_now ? now_i : stamp_i;
  assign elapsed    = now_i - stamp_o;

  assign has_base = (last_press_i != '0);
  assign diff     = signed'({1'b0, press_i}) - signed'({1'b0, last_press_i});
  assign rise     = diff > signed'({1'b0, cfg_i.pressure_rise_limit});

  always_comb begin
    flags_o.launched     = flags_i.launched | launch_now;
    flags_o.deploy_armed = flags_i.deploy_armed |
                           (flags_o.launched && (elapsed >= TIME_BITS'(cfg_i.deploy_delay_us)));
    flags_o.falling      = flags_i.falling |
                           (has_base && rise && (mag < cfg_i.still_mag_sq_limit));
    last_press_o         = press_i;
    result_o.deploy      = has_base && flags_o.deploy_armed;
    result_o.launch_seen = flags_o.launched;
    result_o.fall_seen   = flags_o.falling;
  end

endmodule

FILE: rtl/core/launch_and_chute_deploy_detector_unit.sv
// Launch and chute deploy detector, top level. Depends on lcdd_pkg, lcdd_ifs, lcdd_step.
// Pipeline: input register, then result register; a result that is not taken stalls a
// full input stage. Throughput: one sample per cycle while results are taken; the
// evaluation is a single pass of lcdd_step.
// Reset: asynchronous, active low; clears flags, stamp, baseline and loads register defaults.
// The register write port is always ready; writes are meant for idle periods only.
`include "assert_macros.svh"

module launch_and_chute_deploy_detector_unit #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lcdd_sample_if.sink  sample_i,
  lcdd_result_if.source result_o,
  lcdd_cfg_if.sink     cfg_i
);
  import lcdd_pkg::*;

  // Register file
  lcdd_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.launch_mag_sq_limit <= LaunchMagSqReset;
      cfg_q.still_mag_sq_limit  <= StillMagSqReset;
      cfg_q.pressure_rise_limit <= PressRiseReset;
      cfg_q.deploy_delay_us     <= DeployDelayReset;
    end else if (cfg_i.valid) begin
      unique case (lcdd_cfg_idx_e'(cfg_i.index))
        CFG_LAUNCH_MAG_SQ: cfg_q.launch_mag_sq_limit <= cfg_i.data;
        CFG_STILL_MAG_SQ:  cfg_q.still_mag_sq_limit  <= cfg_i.data;
        CFG_PRESS_RISE:    cfg_q.pressure_rise_limit <= cfg_i.data[PressW-1:0];
        CFG_DEPLOY_DELAY:  cfg_q.deploy_delay_us     <= cfg_i.data;
        default: ; // unknown index: write dropped
      endcase
    end
  end

  // Pipeline control: input stage advances whenever the result register is free
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic s1_adv;
  logic in_take;

  assign out_free       = !out_valid_q || result_o.ready;
  assign s1_adv         = s1_valid_q && out_free;
  assign sample_i.ready = !s1_valid_q || out_free;
  assign in_take        = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sample_i.ready) begin
        s1_valid_q <= sample_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Input register (payload, no reset)
  logic signed [AxisW-1:0] ax_q, ay_q, az_q;
  logic [PressW-1:0]       press_q;
  logic [TIME_BITS-1:0]    now_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ax_q    <= sample_i.accel_x;
      ay_q    <= sample_i.accel_y;
      az_q    <= sample_i.accel_z;
      press_q <= sample_i.pressure_tenths;
      now_q   <= sample_i.time_us;
    end
  end

  // Detector state; updated exactly once per sample, when it leaves the input stage
  lcdd_flags_t          flags_q, flags_d;
  logic [TIME_BITS-1:0] stamp_q, stamp_d;
  logic [PressW-1:0]    last_press_q, last_press_d;
  lcdd_result_t         res_d, res_q;

  lcdd_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .ax_i         (ax_q),
    .ay_i         (ay_q),
    .az_i         (az_q),
    .press_i      (press_q),
    .now_i        (now_q),
    .cfg_i        (cfg_q),
    .flags_i      (flags_q),
    .stamp_i      (stamp_q),
    .last_press_i (last_press_q),
    .flags_o      (flags_d),
    .stamp_o      (stamp_d),
    .last_press_o (last_press_d),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q      <= '0;
      stamp_q      <= '0;
      last_press_q <= '0;
    end else if (s1_adv) begin
      flags_q      <= flags_d;
      stamp_q      <= stamp_d;
      last_press_q <= last_press_d;
    end
  end

  // Result register (payload)
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.deploy      = res_q.deploy;
  assign result_o.launch_seen = res_q.launch_seen;
  assign result_o.fall_seen   = res_q.fall_seen;

  // Launch, once latched, stays latched
  `ASSERT_RST(a_launch_sticky, flags_q.launched |=> flags_q.launched, "launch flag dropped")
  // Chute can only be ready after a launch
  `ASSERT_RST(a_ready_needs_launch, !flags_q.deploy_armed || flags_q.launched,
              "chute ready without launch")
  // A shown deploy must agree with the chute ready state
  `ASSERT_RST(a_deploy_ready, (out_valid_q && res_q.deploy) |-> flags_q.deploy_armed,
              "deploy without chute ready")
  // A shown launch must agree with the launch state
  `ASSERT_RST(a_launch_result, (out_valid_q && res_q.launch_seen) |-> flags_q.launched,
              "launch result without launch state")

endmodule

FILE: verif/lcdd_flight_checker.sv
// Scoreboard for the launch and chute deploy detector: tracks register writes,
// predicts one result per accepted sample and compares accepted results in order.
// Depends on lcdd_pkg and the channel interfaces in lcdd_ifs.
module lcdd_flight_checker #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcdd_sample_if      smp_i,
  lcdd_result_if      res_i,
  lcdd_cfg_if         cfg_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);
  import lcdd_pkg::*;

  // Mirror of the detector's registers and flight state.
  lcdd_cfg_t            regs;
  logic                 launched;
  logic                 deploy_armed;
  logic                 falling;
  logic [TIME_BITS-1:0] launch_stamp;
  logic [PressW-1:0]    last_press;

  lcdd_result_t         flags_due_q[$];
  int unsigned          fails;

  assign fail_cnt_o = fails;

  function automatic lcdd_result_t detector_next(input logic signed [AxisW-1:0] ax,
                                                 input logic signed [AxisW-1:0] ay,
                                                 input logic signed [AxisW-1:0] az,
                                                 input logic [PressW-1:0]       press,
                                                 input logic [TIME_BITS-1:0]    now);
    longint               sx, sy, sz, mag;
    logic [TIME_BITS-1:0] elapsed;
    int                   rise;
    lcdd_result_t         r;
    sx = ax;
    sy = ay;
    sz = az;
    mag = sx * sx + sy * sy + sz * sz;
    r.deploy = 1'b0;

    if (!launched && mag > longint'(regs.launch_mag_sq_limit)) begin
      launched = 1'b1;
      launch_stamp = now;
    end
    if (launched && !deploy_armed) begin
      elapsed = now - launch_stamp;  // wraps at TIME_BITS
      if (elapsed >= TIME_BITS'(regs.deploy_delay_us)) deploy_armed = 1'b1;
    end

    if (last_press == '0) begin
      last_press = press;
    end else begin
      rise = int'(press) - int'(last_press);
      last_press = press;
      if (rise > int'(regs.pressure_rise_limit) && mag < longint'(regs.still_mag_sq_limit))
        falling = 1'b1;
      r.deploy = deploy_armed;
    end

    r.launch_seen = launched;
    r.fall_seen = falling;
    return r;
  endfunction

  task automatic check_flag(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s mismatch: expected %0b, actual %0b", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lcdd_result_t want;
    if (!rst_ni) begin
      regs.launch_mag_sq_limit <= LaunchMagSqReset;
      regs.still_mag_sq_limit  <= StillMagSqReset;
      regs.pressure_rise_limit <= PressRiseReset;
      regs.deploy_delay_us     <= DeployDelayReset;
      launched     <= 1'b0;
      deploy_armed <= 1'b0;
      falling      <= 1'b0;
      launch_stamp <= '0;
      last_press   <= '0;
      flags_due_q.delete();
      pending_o    <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_LAUNCH_MAG_SQ: regs.launch_mag_sq_limit = cfg_i.data[MagW-1:0];
          CFG_STILL_MAG_SQ:  regs.still_mag_sq_limit  = cfg_i.data[MagW-1:0];
          CFG_PRESS_RISE:    regs.pressure_rise_limit = cfg_i.data[PressW-1:0];
          CFG_DEPLOY_DELAY:  regs.deploy_delay_us     = cfg_i.data;
          default: ;
        endcase
      end

      if (res_i.valid && res_i.ready) begin
        if (flags_due_q.size() == 0) begin
          $error("result item with no sample outstanding");
          fails++;
        end else begin
          want = flags_due_q.pop_front();
          check_flag("deploy", want.deploy, res_i.deploy);
          check_flag("launch_seen", want.launch_seen, res_i.launch_seen);
          check_flag("fall_seen", want.fall_seen, res_i.fall_seen);
        end
      end

      if (smp_i.valid && smp_i.ready)
        flags_due_q.push_back(detector_next(smp_i.accel_x, smp_i.accel_y, smp_i.accel_z,
                                            smp_i.pressure_tenths, smp_i.time_us));

      pending_o <= flags_due_q.size();
    end
  end

endmodule

FILE: verif/tb.sv
// Testbench top for launch_and_chute_deploy_detector_unit: clock, reset, sample,
// result and register traffic, verdict. Depends on lcdd_pkg, lcdd_ifs,
// lcdd_flight_checker and the detector RTL.
module tb;
  import lcdd_pkg::*;

  localparam int unsigned TIME_BITS   = 48;
  localparam int unsigned RandItems   = 850;
  localparam int unsigned Phases      = 6;
  localparam int unsigned HoldCycles  = 300;     // long result back-pressure stretch
  localparam int unsigned CycleLimit  = 400000;  // limit for the watchdog

  localparam logic signed [AxisW-1:0] AxisMin   = 16'sh8000;
  localparam logic signed [AxisW-1:0] AxisMax   = 16'sh7FFF;
  localparam logic [MagW-1:0]         MagSqMax  = 32'hC000_0000;  // 3 * 32768^2
  localparam logic [CfgIdxW-1:0]      CfgIdxUnused = 4'hF;        // no register here
  localparam logic [TIME_BITS-1:0]    TimeMax   = '1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lcdd_sample_if #(.TIME_BITS(TIME_BITS)) smp_if ();
  lcdd_result_if                          res_if ();
  lcdd_cfg_if                             cfg_if ();

  int unsigned fails;
  int unsigned pending;

  // Stimulus knobs shared with the result-side process.
  bit idle_on  = 1'b1;  // random bubbles on both channels
  bit hold_req = 1'b0;  // one-shot request for a long result stall

  // Sample stream state for the random flight profile.
  logic [PressW-1:0]    press_now = '0;
  logic [TIME_BITS-1:0] clock_us  = '0;

  always #2 clk_i = ~clk_i;

  launch_and_chute_deploy_detector_unit #(.TIME_BITS(TIME_BITS)) u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  lcdd_flight_checker #(.TIME_BITS(TIME_BITS)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .smp_i      (smp_if),
    .res_i      (res_if),
    .cfg_i      (cfg_if),
    .fail_cnt_o (fails),
    .pending_o  (pending)
  );

  // Offer one sample; optionally drop valid for a bubble first. Returns right
  // after the accepting edge with valid still high, so back-to-back items never
  // toggle valid within one step.
  task automatic send_sample(input logic signed [AxisW-1:0] ax,
                             input logic signed [AxisW-1:0] ay,
                             input logic signed [AxisW-1:0] az,
                             input logic [PressW-1:0]       p,
                             input logic [TIME_BITS-1:0]    t);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    smp_if.valid           <= 1'b1;
    smp_if.accel_x         <= ax;
    smp_if.accel_y         <= ay;
    smp_if.accel_z         <= az;
    smp_if.pressure_tenths <= p;
    smp_if.time_us         <= t;
    do @(posedge clk_i); while (!smp_if.ready);
  endtask

  // Stop sending and wait until every predicted result has come back, then wait
  // on to cover the two-stage pipeline.
  task automatic settle();
    smp_if.valid <= 1'b0;
    @(posedge clk_i);  // pending count is registered and lags the accept edge
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write; valid is lowered only after the last one of a batch.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value,
                           input bit last);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (last) cfg_if.valid <= 1'b0;
  endtask

  // Threshold choice for a random phase: extremes, reset value or anything between.
  function automatic logic [31:0] pick_limit(input logic [31:0] hi, input logic [31:0] dflt);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return hi;
      2:       return dflt;
      default: return $urandom_range(hi, 0);
    endcase
  endfunction

  // One sample of the random flight: mostly drifting pressure and rising time,
  // with dropouts, jumps and wraps mixed in.
  task automatic random_sample();
    logic signed [AxisW-1:0] ax [3];
    logic [63:0]             w;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 3))
        0:       ax[i] = 16'($urandom_range(0, 400) - 200);
        1:       ax[i] = $urandom_range(0, 1) ? AxisMax : AxisMin;
        default: ax[i] = 16'($urandom);
      endcase
    end
    case ($urandom_range(0, 7))
      0:       press_now = '0;                 // sensor dropout
      1:       press_now = 16'($urandom);
      default: press_now = press_now + 16'($urandom_range(0, 40)) - 16'd20;
    endcase
    if ($urandom_range(0, 15) == 0) begin
      w = {$urandom, $urandom};
      clock_us = w[TIME_BITS-1:0];
    end else begin
      clock_us = clock_us + TIME_BITS'($urandom_range(1, 20000));
    end
    send_sample(ax[0], ax[1], ax[2], press_now, clock_us);
  endtask

  // Result side: ready in random bursts, one long stall on request.
  initial begin
    res_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Watchdog.
  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CycleLimit) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("** launch_and_chute_deploy_detector_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    bit                   same_step;  // launch and chute ready on one sample
    logic [TIME_BITS-1:0] t_launch;
    logic [63:0]          w;

    smp_if.valid           <= 1'b0;
    smp_if.accel_x         <= '0;
    smp_if.accel_y         <= '0;
    smp_if.accel_z         <= '0;
    smp_if.pressure_tenths <= '0;
    smp_if.time_us         <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.index           <= CFG_LAUNCH_MAG_SQ;
    cfg_if.data            <= '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed, part 1: nothing can latch ----
    // Launch limit at the largest possible magnitude (equal is not above),
    // stillness limit 0 (never below), rise limit max written with junk in the
    // upper half, longest delay, plus a write to an unused index.
    write_reg(CFG_LAUNCH_MAG_SQ, MagSqMax, 1'b0);
    write_reg(CFG_STILL_MAG_SQ, '0, 1'b0);
    write_reg(CFG_PRESS_RISE, 32'hABCD_FFFF, 1'b0);
    write_reg(CFG_DEPLOY_DELAY, 32'hFFFF_FFFF, 1'b0);
    write_reg(CfgIdxUnused, 32'h1234_5678, 1'b1);

    send_sample('0, '0, '0, '0, '0);                      // no baseline, stores 0
    send_sample(16'sd7, '0, '0, '0, 48'd1);               // stored 0 keeps it so
    send_sample(AxisMin, AxisMin, AxisMin, 16'd1, TimeMax);  // magnitude == limit
    send_sample(AxisMax, AxisMin, AxisMax, 16'hFFFF, '0); // rise one below limit
    send_sample('0, '0, '0, '0, 48'd5);                   // drop to 0: baseline lost
    send_sample('0, '0, '0, 16'd500, 48'd6);              // new baseline
    send_sample('0, '0, '0, 16'd100, 48'd7);              // pressure drop
    settle();

    // ---- Directed, part 2: fall, launch, chute ready ----
    // Either launch and chute ready on the same sample (zero delay), or a
    // launch just below the time wrap with the delay elapsing across it.
    same_step = 1'($urandom_range(0, 1));
    w = {$urandom, $urandom};
    t_launch = same_step ? w[TIME_BITS-1:0] : TimeMax - TIME_BITS'(499);
    write_reg(CFG_STILL_MAG_SQ, MagSqMax, 1'b0);
    write_reg(CFG_PRESS_RISE, '0, 1'b0);
    write_reg(CFG_LAUNCH_MAG_SQ, '0, 1'b0);
    write_reg(CFG_DEPLOY_DELAY, same_step ? 32'd0 : 32'd1000, 1'b1);

    send_sample('0, '0, '0, 16'd101, t_launch - TIME_BITS'(1));  // rise of 1: falling
    send_sample(16'sd1, '0, '0, 16'd101, t_launch);              // smallest launch
    send_sample('0, '0, '0, 16'd101, t_launch + TIME_BITS'(999));
    send_sample('0, '0, '0, 16'd101, t_launch + TIME_BITS'(1000));
    send_sample('0, '0, '0, '0, t_launch + TIME_BITS'(1001));    // ready, no baseline
    send_sample('0, '0, '0, 16'd200, t_launch + TIME_BITS'(1002));
    send_sample('0, '0, '0, 16'd201, t_launch + TIME_BITS'(1003));
    clock_us = t_launch + TIME_BITS'(1003);
    press_now = 16'd201;

    // ---- Random phases, fresh register settings each ----
    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      write_reg(CFG_LAUNCH_MAG_SQ, pick_limit(MagSqMax, LaunchMagSqReset), 1'b0);
      write_reg(CFG_STILL_MAG_SQ, pick_limit(MagSqMax, StillMagSqReset), 1'b0);
      write_reg(CFG_PRESS_RISE,
                {16'($urandom), 16'(pick_limit(32'hFFFF, 32'(PressRiseReset)))}, 1'b0);
      write_reg(CFG_DEPLOY_DELAY, pick_limit(32'hFFFF_FFFF, DeployDelayReset), 1'b1);
      if (ph == 1) hold_req = 1'b1;           // fill the pipe against a stalled sink
      if (ph == Phases - 1) idle_on = 1'b0;   // closing stretch at full rate
      repeat (RandItems / Phases) random_sample();
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (fails == 0) begin
      $display("** launch_and_chute_deploy_detector_unit: PASSED **");
    end else begin
      $display("** launch_and_chute_deploy_detector_unit: FAILED **");
    end
    $finish;
  end

endmodule
